FILE: rtl/core/rgbir_bilinear_remosaic_assert.svh
// Assertion macros for the RGB-IR remosaic block.
// Used by the top level only; needs nothing else.
`ifndef RGBIR_BILINEAR_REMOSAIC_ASSERT_SVH
`define RGBIR_BILINEAR_REMOSAIC_ASSERT_SVH

// Consequence must hold in the same cycle as the antecedent.
`define RBR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rgbir remosaic: same-cycle check failed");

// Consequence must hold in the cycle after the antecedent.
`define RBR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rgbir remosaic: next-cycle check failed");

`endif

FILE: rtl/core/rbr_pkg.sv
// Shared constants, types and the colour-site table of the RGB-IR remosaic.
// No dependencies.
package rbr_pkg;

   // Sizes
   localparam int MAX_WIDTH   = 4096;
   localparam int MAX_HEIGHT  = 4096;
   localparam int MIN_SIZE    = 8;
   localparam int PIXEL_BITS  = 12;
   localparam int RAW_BITS    = 16;
   localparam int BIT_SHIFT   = RAW_BITS - PIXEL_BITS;
   localparam int COL_BITS    = $clog2(MAX_WIDTH);
   localparam int ROW_BITS    = $clog2(MAX_HEIGHT);
   localparam int SIZE_BITS   = 13;
   localparam int RING_ROWS   = 8;
   localparam int RING_BITS   = $clog2(RING_ROWS);
   localparam int WIN_TAPS    = 7;
   localparam int TAP_BITS    = 3;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   // Window tap positions, relative to the centre column
   localparam logic [TAP_BITS-1:0] TAP_M3 = 3'd0;
   localparam logic [TAP_BITS-1:0] TAP_M2 = 3'd1;
   localparam logic [TAP_BITS-1:0] TAP_M1 = 3'd2;
   localparam logic [TAP_BITS-1:0] TAP_C  = 3'd3;
   localparam logic [TAP_BITS-1:0] TAP_P1 = 3'd4;
   localparam logic [TAP_BITS-1:0] TAP_P2 = 3'd5;
   localparam logic [TAP_BITS-1:0] TAP_P3 = 3'd6;

   // Register map
   typedef enum logic [1:0] {
      REG_CFA_PATTERN  = 2'd0,
      REG_FRAME_WIDTH  = 2'd1,
      REG_FRAME_HEIGHT = 2'd2
   } reg_index_type;

   localparam logic [1:0]           RST_CFA_PATTERN  = 2'd0;
   localparam logic [SIZE_BITS-1:0] RST_FRAME_WIDTH  = 13'd1920;
   localparam logic [SIZE_BITS-1:0] RST_FRAME_HEIGHT = 13'd1080;

   // Colour sites
   typedef enum logic [1:0] {
      SITE_R = 2'd0,
      SITE_G = 2'd1,
      SITE_B = 2'd2,
      SITE_I = 2'd3
   } site_type;

   // IR plane interpolation
   typedef enum logic [1:0] {
      IR_PASS = 2'd0,
      IR_DIAG = 2'd1,
      IR_VERT = 2'd2,
      IR_HORZ = 2'd3
   } ir_mode_type;

   // Bayer plane interpolation
   typedef enum logic [1:0] {
      BAY_PASS  = 2'd0,
      BAY_ANTI  = 2'd1,
      BAY_MAIN  = 2'd2,
      BAY_CROSS = 2'd3
   } bay_mode_type;

   // Per-output neighbourhood selection: ring rows and window taps
   typedef struct packed {
      ir_mode_type           ir_mode;
      bay_mode_type          bay_mode;
      logic [RING_BITS-1:0]  r0;
      logic [RING_BITS-1:0]  rm1;
      logic [RING_BITS-1:0]  rp1;
      logic [RING_BITS-1:0]  rm2;
      logic [RING_BITS-1:0]  rp2;
      logic [RING_BITS-1:0]  wm1;
      logic [RING_BITS-1:0]  wp1;
      logic [TAP_BITS-1:0]   cm1;
      logic [TAP_BITS-1:0]   cp1;
      logic [TAP_BITS-1:0]   cm2;
      logic [TAP_BITS-1:0]   cp2;
      logic [TAP_BITS-1:0]   wcm1;
      logic [TAP_BITS-1:0]   wcp1;
   } geom_type;

   // One pipeline beat: a line-buffer column read, optionally with an output
   typedef struct packed {
      logic                  emit;
      logic [COL_BITS-1:0]   rd_col;
      logic                  line_end;
      logic                  frame_end;
      geom_type              geom;
   } beat_type;

   typedef logic [RING_ROWS-1:0][PIXEL_BITS-1:0] column_type;
   typedef column_type [WIN_TAPS-1:0]            window_type;

   // Site of each phase of the 4x4 pattern, indexed by pattern and {row, col}
   localparam site_type SITE_MAP [4][16] = '{
      '{SITE_R, SITE_G, SITE_B, SITE_G, SITE_G, SITE_I, SITE_G, SITE_I,
        SITE_B, SITE_G, SITE_R, SITE_G, SITE_G, SITE_I, SITE_G, SITE_I},
      '{SITE_G, SITE_R, SITE_G, SITE_B, SITE_I, SITE_G, SITE_I, SITE_G,
        SITE_G, SITE_B, SITE_G, SITE_R, SITE_I, SITE_G, SITE_I, SITE_G},
      '{SITE_B, SITE_G, SITE_R, SITE_G, SITE_G, SITE_I, SITE_G, SITE_I,
        SITE_R, SITE_G, SITE_B, SITE_G, SITE_G, SITE_I, SITE_G, SITE_I},
      '{SITE_G, SITE_B, SITE_G, SITE_R, SITE_I, SITE_G, SITE_I, SITE_G,
        SITE_G, SITE_R, SITE_G, SITE_B, SITE_I, SITE_G, SITE_I, SITE_G}
   };

   function automatic site_type site_of(input logic [1:0] pat, input logic [1:0] r2,
                                        input logic [1:0] c2);
      return SITE_MAP[pat][{r2, c2}];
   endfunction

endpackage

FILE: rtl/core/rbr_line_ram.sv
// One line of the line buffer: MAX_WIDTH pixels, one write and one registered read port.
// Depends on rbr_pkg.
module rbr_line_ram
   import rbr_pkg::*;
(
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [COL_BITS-1:0]   wr_addr,
   input  logic [PIXEL_BITS-1:0] wr_data,
   input  logic                  rd_en,
   input  logic [COL_BITS-1:0]   rd_addr,
   output logic [PIXEL_BITS-1:0] rd_data
);

   logic [PIXEL_BITS-1:0] mem [MAX_WIDTH];
   logic [PIXEL_BITS-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port; data is held while the read enable is low.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/rbr_ctrl.sv
// Frame counters of the remosaic: input and output positions, line-buffer writes
// and the neighbourhood selection for each output. Depends on rbr_pkg.
module rbr_ctrl
   import rbr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic                  is_blank,
   input  logic                  restart,
   input  logic [1:0]            cfa_pattern,
   input  logic [SIZE_BITS-1:0]  frame_width,
   input  logic [SIZE_BITS-1:0]  frame_height,
   output logic                  wr_en,
   output logic [RING_BITS-1:0]  wr_bank,
   output logic [COL_BITS-1:0]   wr_col,
   output logic                  beat_valid,
   output beat_type              beat
);

   logic [ROW_BITS-1:0]  in_row_ff, in_row_in;
   logic [COL_BITS-1:0]  in_col_ff, in_col_in;
   logic                 rx_done_ff, rx_done_in;
   logic [ROW_BITS-1:0]  out_row_ff, out_row_in;
   logic [COL_BITS-1:0]  out_col_ff, out_col_in;

   logic [SIZE_BITS-1:0] w_used, h_used;
   logic [COL_BITS-1:0]  mc;
   logic [ROW_BITS-1:0]  mr;
   logic                 pix_beat, rd_go, emit, le, fe;
   logic [RING_BITS-1:0] rr;
   logic                 row_top, row_second, row_last, row_penult;
   logic                 col_first, col_second, col_last, col_penult;
   site_type             site;
   logic [1:0]           r2, c2;
   geom_type             geom;

   // Clamp the frame size to the supported range.
   always_comb begin
      w_used = frame_width;
      if (frame_width < SIZE_BITS'(MIN_SIZE)) w_used = SIZE_BITS'(MIN_SIZE);
      else if (frame_width > SIZE_BITS'(MAX_WIDTH)) w_used = SIZE_BITS'(MAX_WIDTH);
      h_used = frame_height;
      if (frame_height < SIZE_BITS'(MIN_SIZE)) h_used = SIZE_BITS'(MIN_SIZE);
      else if (frame_height > SIZE_BITS'(MAX_HEIGHT)) h_used = SIZE_BITS'(MAX_HEIGHT);
   end

   assign mc = COL_BITS'(w_used - SIZE_BITS'(1));
   assign mr = ROW_BITS'(h_used - SIZE_BITS'(1));

   // Beat classification. A column is read once two full lines lie below it, and
   // an output follows three columns later. After the last pixel every beat flushes.
   assign pix_beat = !rx_done_ff && !is_blank;
   assign rd_go    = rx_done_ff || (pix_beat && (in_row_ff >= ROW_BITS'(2)));
   assign emit     = rx_done_ff || (pix_beat && ((in_row_ff > ROW_BITS'(2)) ||
                     ((in_row_ff == ROW_BITS'(2)) && (in_col_ff >= COL_BITS'(3)))));
   assign le       = out_col_ff == mc;
   assign fe       = le && (out_row_ff == mr);

   assign wr_en   = accept && pix_beat;
   assign wr_bank = in_row_ff[RING_BITS-1:0];
   assign wr_col  = in_col_ff;

   // Counter updates
   always_comb begin
      in_row_in  = in_row_ff;
      in_col_in  = in_col_ff;
      rx_done_in = rx_done_ff;
      out_row_in = out_row_ff;
      out_col_in = out_col_ff;
      if (restart) begin
         in_row_in  = '0;
         in_col_in  = '0;
         rx_done_in = 1'b0;
         out_row_in = '0;
         out_col_in = '0;
      end else if (accept) begin
         if (pix_beat || rx_done_ff) begin
            in_col_in = (in_col_ff == mc) ? '0 : in_col_ff + COL_BITS'(1);
         end
         if (pix_beat && (in_col_ff == mc)) begin
            if (in_row_ff == mr) begin
               rx_done_in = 1'b1;
            end else begin
               in_row_in = in_row_ff + ROW_BITS'(1);
            end
         end
         if (emit) begin
            if (fe) begin
               in_row_in  = '0;
               in_col_in  = '0;
               rx_done_in = 1'b0;
               out_row_in = '0;
               out_col_in = '0;
            end else if (le) begin
               out_col_in = '0;
               out_row_in = out_row_ff + ROW_BITS'(1);
            end else begin
               out_col_in = out_col_ff + COL_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_row_ff  <= '0;
         in_col_ff  <= '0;
         rx_done_ff <= 1'b0;
         out_row_ff <= '0;
         out_col_ff <= '0;
      end else begin
         in_row_ff  <= in_row_in;
         in_col_ff  <= in_col_in;
         rx_done_ff <= rx_done_in;
         out_row_ff <= out_row_in;
         out_col_ff <= out_col_in;
      end
   end

   // Edge conditions of the output position
   assign rr         = out_row_ff[RING_BITS-1:0];
   assign row_top    = out_row_ff == '0;
   assign row_second = out_row_ff == ROW_BITS'(1);
   assign row_last   = out_row_ff == mr;
   assign row_penult = out_row_ff == (mr - ROW_BITS'(1));
   assign col_first  = out_col_ff == '0;
   assign col_second = out_col_ff == COL_BITS'(1);
   assign col_last   = out_col_ff == mc;
   assign col_penult = out_col_ff == (mc - COL_BITS'(1));
   assign r2         = out_row_ff[1:0];
   assign c2         = out_col_ff[1:0];
   assign site       = site_of(cfa_pattern, r2, c2);

   // Neighbourhood: mirrored rows and columns for the crosses and diagonals,
   // wrap-by-four for the IR fill of the Bayer plane.
   always_comb begin
      geom.r0  = rr;
      geom.rm1 = row_top ? RING_BITS'(1) : rr - RING_BITS'(1);
      geom.rp1 = row_last ? rr - RING_BITS'(1) : rr + RING_BITS'(1);
      geom.rm2 = row_top ? RING_BITS'(2) : (row_second ? RING_BITS'(1) : rr - RING_BITS'(2));
      geom.rp2 = row_last ? rr - RING_BITS'(2) : (row_penult ? rr : rr + RING_BITS'(2));
      geom.wm1 = row_top ? RING_BITS'(3) : rr - RING_BITS'(1);
      geom.wp1 = row_last ? rr - RING_BITS'(3) : rr + RING_BITS'(1);

      geom.cm1  = col_first ? TAP_P1 : TAP_M1;
      geom.cp1  = col_last ? TAP_M1 : TAP_P1;
      geom.cm2  = col_first ? TAP_P2 : (col_second ? TAP_C : TAP_M2);
      geom.cp2  = col_last ? TAP_M2 : (col_penult ? TAP_C : TAP_P2);
      geom.wcm1 = col_first ? TAP_P3 : TAP_M1;
      geom.wcp1 = col_last ? TAP_M3 : TAP_P1;

      case (site)
         SITE_R, SITE_B: geom.ir_mode = IR_DIAG;
         SITE_G:         geom.ir_mode = out_row_ff[0] ? IR_HORZ : IR_VERT;
         default:        geom.ir_mode = IR_PASS;
      endcase

      if (site == SITE_I) begin
         if (!cfa_pattern[0]) begin
            geom.bay_mode = (r2 == c2) ? BAY_ANTI : BAY_MAIN;
         end else begin
            geom.bay_mode = ({1'b0, r2} == ({1'b0, c2} + 3'd1)) ? BAY_MAIN : BAY_ANTI;
         end
      end else if (((site == SITE_B) && !cfa_pattern[1]) ||
                   ((site == SITE_R) && cfa_pattern[1])) begin
         geom.bay_mode = BAY_CROSS;
      end else begin
         geom.bay_mode = BAY_PASS;
      end
   end

   // Beat handed to the pipeline
   assign beat_valid     = accept && rd_go;
   assign beat.emit      = emit;
   assign beat.rd_col    = in_col_ff;
   assign beat.line_end  = le;
   assign beat.frame_end = fe;
   assign beat.geom      = geom;

endmodule

FILE: rtl/core/rbr_interp.sv
// Interpolation datapath: IR and Bayer samples from the seven-column window.
// Depends on rbr_pkg.
module rbr_interp
   import rbr_pkg::*;
(
   input  window_type            win,
   input  geom_type              geom,
   output logic [PIXEL_BITS-1:0] bayer,
   output logic [PIXEL_BITS-1:0] ir
);

   logic [PIXEL_BITS+1:0] ir_sum4, bay_sum4;
   logic [PIXEL_BITS:0]   ir_sum2, bay_sum2;
   logic [PIXEL_BITS-1:0] self_pix;

   assign self_pix = win[TAP_C][geom.r0];

   // IR plane
   always_comb begin
      ir_sum4 = (PIXEL_BITS+2)'(win[geom.cm1][geom.rm1]) + (PIXEL_BITS+2)'(win[geom.cp1][geom.rm1])
              + (PIXEL_BITS+2)'(win[geom.cm1][geom.rp1]) + (PIXEL_BITS+2)'(win[geom.cp1][geom.rp1]);
      ir_sum2 = '0;
      ir      = self_pix;
      case (geom.ir_mode)
         IR_DIAG: ir = PIXEL_BITS'((ir_sum4 + (PIXEL_BITS+2)'(2)) >> 2);
         IR_VERT: begin
            ir_sum2 = (PIXEL_BITS+1)'(win[TAP_C][geom.rm1]) + (PIXEL_BITS+1)'(win[TAP_C][geom.rp1]);
            ir      = PIXEL_BITS'((ir_sum2 + (PIXEL_BITS+1)'(1)) >> 1);
         end
         IR_HORZ: begin
            ir_sum2 = (PIXEL_BITS+1)'(win[geom.cm1][geom.r0]) + (PIXEL_BITS+1)'(win[geom.cp1][geom.r0]);
            ir      = PIXEL_BITS'((ir_sum2 + (PIXEL_BITS+1)'(1)) >> 1);
         end
         default: ir = self_pix;
      endcase
   end

   // Bayer plane
   always_comb begin
      bay_sum4 = (PIXEL_BITS+2)'(win[geom.cm2][geom.r0]) + (PIXEL_BITS+2)'(win[geom.cp2][geom.r0])
               + (PIXEL_BITS+2)'(win[TAP_C][geom.rm2]) + (PIXEL_BITS+2)'(win[TAP_C][geom.rp2]);
      bay_sum2 = '0;
      bayer    = self_pix;
      case (geom.bay_mode)
         BAY_ANTI: begin
            bay_sum2 = (PIXEL_BITS+1)'(win[geom.wcp1][geom.wm1])
                     + (PIXEL_BITS+1)'(win[geom.wcm1][geom.wp1]);
            bayer    = PIXEL_BITS'((bay_sum2 + (PIXEL_BITS+1)'(1)) >> 1);
         end
         BAY_MAIN: begin
            bay_sum2 = (PIXEL_BITS+1)'(win[geom.wcm1][geom.wm1])
                     + (PIXEL_BITS+1)'(win[geom.wcp1][geom.wp1]);
            bayer    = PIXEL_BITS'((bay_sum2 + (PIXEL_BITS+1)'(1)) >> 1);
         end
         BAY_CROSS: bayer = PIXEL_BITS'((bay_sum4 + (PIXEL_BITS+2)'(2)) >> 2);
         default:   bayer = self_pix;
      endcase
   end

endmodule

FILE: rtl/core/rgbir_bilinear_remosaic.sv
// Top level of the RGB-IR 4x4 bilinear remosaic: register port, line buffer,
// window and pipeline. Depends on rbr_pkg, rbr_line_ram, rbr_ctrl, rbr_interp.
//
// The block takes one raw pixel per clock in raster order and gives one
// remosaiced Bayer sample and one IR sample per clock while the output is not
// stalled, with no stall of its own. Each beat passes three registers (beat,
// line-buffer read, result) on its way to the output. Results run 2*W+3 pixels
// behind the input, W being the clamped line width; after the last pixel of a
// frame, every further beat (blank or not) releases one pending result until the
// frame end result has gone out. The line buffer is eight banks of MAX_WIDTH
// pixels of one write and one read port each; its contents are never cleared and
// need no clearing pass. Writing any register restarts the frame and should only
// be done while the block is idle.
`include "rgbir_bilinear_remosaic_assert.svh"

module rgbir_bilinear_remosaic
   import rbr_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // Pixel input
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [RAW_BITS-1:0]      req_raw_pixel,
   input  logic                     req_is_blank,
   // Result output
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [RAW_BITS-1:0]      rsp_bayer_out,
   output logic [RAW_BITS-1:0]      rsp_ir_out,
   output logic                     rsp_line_end,
   output logic                     rsp_frame_end,
   // Register port
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   logic [1:0]           cfa_pattern_ff, cfa_pattern_in;
   logic [SIZE_BITS-1:0] frame_width_ff, frame_width_in;
   logic [SIZE_BITS-1:0] frame_height_ff, frame_height_in;
   logic                 csr_wr, restart;
   reg_index_type        csr_index;

   logic                 accept;
   logic                 wr_en;
   logic [RING_BITS-1:0] wr_bank;
   logic [COL_BITS-1:0]  wr_col;
   logic                 beat_valid;
   beat_type             beat;

   logic                 a_valid_ff, a_valid_in;
   beat_type             a_beat_ff, a_beat_in;
   logic                 b_valid_ff, b_valid_in;
   beat_type             b_beat_ff, b_beat_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [PIXEL_BITS-1:0] bayer_ff, bayer_in, ir_ff, ir_in;
   logic                 line_end_ff, line_end_in, frame_end_ff, frame_end_in;

   logic                 a_adv, a_free, b_adv, b_free, c_free;
   column_type           bank_data;
   window_type           win_ff, win_in;
   logic [PIXEL_BITS-1:0] bay_calc, ir_calc;

   // Register port
   assign pready    = 1'b1;
   assign csr_wr    = psel && penable && pwrite;
   assign csr_index = reg_index_type'(paddr[CSR_ADDR_BITS-1:2]);

   always_comb begin
      cfa_pattern_in  = cfa_pattern_ff;
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      restart         = 1'b0;
      if (csr_wr) begin
         case (csr_index)
            REG_CFA_PATTERN: begin
               cfa_pattern_in = pwdata[1:0];
               restart        = 1'b1;
            end
            REG_FRAME_WIDTH: begin
               frame_width_in = pwdata[SIZE_BITS-1:0];
               restart        = 1'b1;
            end
            REG_FRAME_HEIGHT: begin
               frame_height_in = pwdata[SIZE_BITS-1:0];
               restart         = 1'b1;
            end
            default: restart = 1'b0;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_CFA_PATTERN:  prdata = CSR_DATA_BITS'(cfa_pattern_ff);
         REG_FRAME_WIDTH:  prdata = CSR_DATA_BITS'(frame_width_ff);
         REG_FRAME_HEIGHT: prdata = CSR_DATA_BITS'(frame_height_ff);
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfa_pattern_ff  <= RST_CFA_PATTERN;
         frame_width_ff  <= RST_FRAME_WIDTH;
         frame_height_ff <= RST_FRAME_HEIGHT;
      end else begin
         cfa_pattern_ff  <= cfa_pattern_in;
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
      end
   end

   // Pipeline flow: each stage moves on when the next one is free or moving.
   // Beats that only read a column do not need the result register.
   assign c_free    = !rsp_valid_ff || !rsp_stall;
   assign b_adv     = b_valid_ff && (!b_beat_ff.emit || c_free);
   assign b_free    = !b_valid_ff || b_adv;
   assign a_adv     = a_valid_ff && b_free;
   assign a_free    = !a_valid_ff || a_adv;
   assign req_stall = !a_free;
   assign accept    = req_valid && !req_stall;

   // Frame counters and neighbourhood selection
   rbr_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .is_blank     (req_is_blank),
      .restart      (restart),
      .cfa_pattern  (cfa_pattern_ff),
      .frame_width  (frame_width_ff),
      .frame_height (frame_height_ff),
      .wr_en        (wr_en),
      .wr_bank      (wr_bank),
      .wr_col       (wr_col),
      .beat_valid   (beat_valid),
      .beat         (beat)
   );

   // Line buffer: one bank per ring line, all banks read at the same column.
   for (genvar g = 0; g < RING_ROWS; g++) begin : g_bank
      rbr_line_ram u_ram (
         .clock   (clock),
         .wr_en   (wr_en && (wr_bank == RING_BITS'(g))),
         .wr_addr (wr_col),
         .wr_data (req_raw_pixel[RAW_BITS-1:BIT_SHIFT]),
         .rd_en   (a_adv),
         .rd_addr (a_beat_ff.rd_col),
         .rd_data (bank_data[g])
      );
   end

   // Beat and read stages
   always_comb begin
      a_valid_in = a_valid_ff;
      a_beat_in  = a_beat_ff;
      if (a_free) begin
         a_valid_in = beat_valid;
         a_beat_in  = beat;
      end
      b_valid_in = b_valid_ff;
      b_beat_in  = b_beat_ff;
      if (b_free) begin
         b_valid_in = a_adv;
         b_beat_in  = a_beat_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_beat_ff <= a_beat_in;
      b_beat_ff <= b_beat_in;
   end

   // Seven-column window; the newest column enters at the highest tap.
   always_comb begin
      win_in = win_ff;
      for (int t = 0; t < WIN_TAPS - 1; t++) begin
         win_in[t] = win_ff[t+1];
      end
      win_in[WIN_TAPS-1] = bank_data;
   end

   always_ff @(posedge clock) begin
      if (b_adv) begin
         win_ff <= win_in;
      end
   end

   rbr_interp u_interp (
      .win   (win_in),
      .geom  (b_beat_ff.geom),
      .bayer (bay_calc),
      .ir    (ir_calc)
   );

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      bayer_in     = bayer_ff;
      ir_in        = ir_ff;
      line_end_in  = line_end_ff;
      frame_end_in = frame_end_ff;
      if (c_free) begin
         rsp_valid_in = b_adv && b_beat_ff.emit;
         bayer_in     = bay_calc;
         ir_in        = ir_calc;
         line_end_in  = b_beat_ff.line_end;
         frame_end_in = b_beat_ff.frame_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bayer_ff     <= bayer_in;
      ir_ff        <= ir_in;
      line_end_ff  <= line_end_in;
      frame_end_ff <= frame_end_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_bayer_out = {bayer_ff, {BIT_SHIFT{1'b0}}};
   assign rsp_ir_out    = {ir_ff, {BIT_SHIFT{1'b0}}};
   assign rsp_line_end  = line_end_ff;
   assign rsp_frame_end = frame_end_ff;

   // Checks
   `RBR_ASSERT_SAME(a_fe_has_le, clock, reset, rsp_valid_ff && frame_end_ff, line_end_ff)
   `RBR_ASSERT_NEXT(a_beat_loaded, clock, reset, beat_valid, a_valid_ff)
   `RBR_ASSERT_SAME(a_no_overrun, clock, reset, b_adv && b_beat_ff.emit, !(rsp_valid_ff && rsp_stall))

endmodule

FILE: sim/rgbir_bilinear_remosaic_tb.sv
// Testbench for the RGB-IR bilinear remosaic: random raw frames with flush beats,
// predicted and checked result by result. Depends on rbr_pkg and the block's RTL.
module rgbir_bilinear_remosaic_tb;
   import rbr_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 12;
   // Byte address one past the last register; writes there must be ignored.
   localparam logic [CSR_ADDR_BITS-1:0] SPARE_ADDR = 4'd12;

   typedef struct packed {
      logic [RAW_BITS-1:0] raw;
      logic                blank;
   } raw_beat_type;

   typedef struct packed {
      logic [RAW_BITS-1:0] bayer;
      logic [RAW_BITS-1:0] ir;
      logic                line_end;
      logic                frame_end;
   } remosaic_out_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [RAW_BITS-1:0] req_raw_pixel = '0;
   logic req_is_blank = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [RAW_BITS-1:0] rsp_bayer_out, rsp_ir_out;
   logic rsp_line_end, rsp_frame_end;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] paddr = '0;
   logic [CSR_DATA_BITS-1:0] pwdata = '0;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic pready;

   rgbir_bilinear_remosaic dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Shadow registers and predictor state
   logic [1:0]           pattern_sh = RST_CFA_PATTERN;
   logic [SIZE_BITS-1:0] width_sh = RST_FRAME_WIDTH;
   logic [SIZE_BITS-1:0] height_sh = RST_FRAME_HEIGHT;
   logic [PIXEL_BITS-1:0] ring [RING_ROWS][MAX_WIDTH];
   int in_count = 0, out_row = 0, out_col = 0;

   raw_beat_type     raw_beats [$];
   remosaic_out_type expected_samples [$];
   raw_beat_type     next_beat;
   remosaic_out_type got;
   remosaic_out_type want;
   int errors = 0, checked = 0, frames_done = 0, cycles = 0;
   int queued = 0;
   bit calm = 1'b0;
   bit held_once = 1'b0;
   int hold_left = 0;

   function automatic int clamp_size(int v);
      if (v < MIN_SIZE) return MIN_SIZE;
      if (v > MAX_WIDTH) return MAX_WIDTH;
      return v;
   endfunction

   function automatic int reflect(int x, int top);
      if (x < 0) return -x;
      if (x > top) return 2 * top - x;
      return x;
   endfunction

   function automatic int wrap_by4(int x, int top);
      if (x < 0) return 4 + x;
      if (x > top) return x - 4;
      return x;
   endfunction

   function automatic int px(int r, int c);
      int col;
      col = (c >= MAX_WIDTH) ? MAX_WIDTH - 1 : c;
      return int'(ring[r & 7][col]);
   endfunction

   // Colour of a site, worked out from the phase within the 4x4 tile.
   function automatic site_type site_at(int pat, int r, int c);
      if (r & 1) return ((c & 1) != (pat & 1)) ? SITE_I : SITE_G;
      if ((c & 1) != (pat & 1)) return SITE_G;
      return ((((c >> 1) ^ (r >> 1) ^ (pat >> 1)) & 1) != 0) ? SITE_B : SITE_R;
   endfunction

   function automatic int sat(int v);
      return (v > 4095) ? 4095 : v;
   endfunction

   // Both planes at one output position.
   function automatic void remosaic_at(int r, int c, int w, int h,
                                       output int bay, output int ir);
      int mr, mc, pat, s;
      site_type site;
      bit anti;
      mr = h - 1;
      mc = w - 1;
      pat = int'(pattern_sh);
      site = site_at(pat, r, c);
      if (site == SITE_R || site == SITE_B) begin
         s = px(reflect(r-1, mr), reflect(c-1, mc)) + px(reflect(r-1, mr), reflect(c+1, mc))
           + px(reflect(r+1, mr), reflect(c-1, mc)) + px(reflect(r+1, mr), reflect(c+1, mc));
         ir = sat((s + 2) / 4);
      end else if (site == SITE_G) begin
         if ((r & 1) == 0)
            s = px(reflect(r-1, mr), c) + px(reflect(r+1, mr), c);
         else
            s = px(r, reflect(c-1, mc)) + px(r, reflect(c+1, mc));
         ir = sat((s + 1) / 2);
      end else begin
         ir = px(r, c);
      end
      bay = px(r, c);
      if (site == SITE_I) begin
         if (pat == 0 || pat == 2)
            anti = (r & 3) == (c & 3);
         else
            anti = !((r & 3) == (c & 3) + 1);
         if (anti)
            s = px(wrap_by4(r-1, mr), wrap_by4(c+1, mc)) + px(wrap_by4(r+1, mr), wrap_by4(c-1, mc));
         else
            s = px(wrap_by4(r-1, mr), wrap_by4(c-1, mc)) + px(wrap_by4(r+1, mr), wrap_by4(c+1, mc));
         bay = sat((s + 1) / 2);
      end else if ((site == SITE_B && pat < 2) || (site == SITE_R && pat >= 2)) begin
         s = px(r, reflect(c-2, mc)) + px(r, reflect(c+2, mc))
           + px(reflect(r-2, mr), c) + px(reflect(r+2, mr), c);
         bay = sat((s + 2) / 4);
      end
   endfunction

   function automatic void restart_counts();
      in_count = 0;
      out_row = 0;
      out_col = 0;
   endfunction

   // Append one beat to the stimulus queue and count it.
   function automatic void add_beat(logic [RAW_BITS-1:0] raw, logic blank);
      raw_beat_type b;
      b.raw = raw;
      b.blank = blank;
      raw_beats.insert(raw_beats.size(), b);
      queued++;
   endfunction

   // Advance the predictor by one accepted input beat.
   function automatic void predict_beat(logic [RAW_BITS-1:0] raw, logic blank);
      int w, h, bay, ir;
      bit emit;
      remosaic_out_type e;
      w = clamp_size(int'(width_sh));
      h = clamp_size(int'(height_sh));
      if (in_count < w * h) begin
         if (blank) return;
         ring[(in_count / w) & 7][in_count % w] = PIXEL_BITS'(raw >> BIT_SHIFT);
         in_count++;
         emit = in_count > 2 * w + 3;
      end else begin
         emit = 1'b1;
      end
      if (!emit) return;
      remosaic_at(out_row, out_col, w, h, bay, ir);
      e.bayer = 16'(bay << BIT_SHIFT);
      e.ir = 16'(ir << BIT_SHIFT);
      e.line_end = (out_col == w - 1);
      e.frame_end = e.line_end && (out_row == h - 1);
      expected_samples.insert(expected_samples.size(), e);
      if (e.frame_end) begin
         restart_counts();
         frames_done++;
      end else if (e.line_end) begin
         out_col = 0;
         out_row++;
      end else begin
         out_col++;
      end
   endfunction

   // Input side: a beat is taken when valid is high and stall is low.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            predict_beat(req_raw_pixel, req_is_blank);
         if (!req_valid || !req_stall) begin
            if (raw_beats.size() > 0 && (calm || $urandom_range(99) >= 13)) begin
               next_beat = raw_beats.pop_front();
               req_valid <= 1'b1;
               req_raw_pixel <= next_beat.raw;
               req_is_blank <= next_beat.blank;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Output side: compare every beat with the oldest prediction.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_bayer_out, rsp_ir_out, rsp_line_end, rsp_frame_end};
            if (expected_samples.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected result: bayer %h ir %h le %b fe %b",
                           got.bayer, got.ir, got.line_end, got.frame_end);
            end else begin
               want = expected_samples.pop_front();
               checked++;
               if (got != want) begin
                  errors++;
                  if (errors <= 10)
                     $display("result %0d: expected bayer %h ir %h le %b fe %b, got %h %h %b %b",
                              checked, want.bayer, want.ir, want.line_end, want.frame_end,
                              got.bayer, got.ir, got.line_end, got.frame_end);
               end
            end
         end
         // One long hold-off so that the block fills and stalls its input.
         if (!held_once && checked >= 200) begin
            held_once = 1'b1;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !calm && ($urandom_range(99) < 13);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("Verification failed");
         $finish;
      end
   end

   // Register write: setup cycle, then access cycle.
   task automatic csr_write(logic [CSR_ADDR_BITS-1:0] addr, logic [CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      case (addr)
         REG_CFA_PATTERN * 4:  pattern_sh = value[1:0];
         REG_FRAME_WIDTH * 4:  width_sh = value[SIZE_BITS-1:0];
         REG_FRAME_HEIGHT * 4: height_sh = value[SIZE_BITS-1:0];
         default: ;
      endcase
      if (addr <= REG_FRAME_HEIGHT * 4)
         restart_counts();
   endtask

   task automatic set_frame(int pat, int w, int h);
      csr_write(REG_CFA_PATTERN * 4, pat);
      csr_write(REG_FRAME_WIDTH * 4, w);
      csr_write(REG_FRAME_HEIGHT * 4, h);
   endtask

   // Wait until every beat is in and every result out, then let the pipe drain.
   task automatic settle();
      while (raw_beats.size() > 0 || req_valid || expected_samples.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Pixels with scattered blank beats, then optionally the flush beats.
   task automatic queue_frame(int n_pix, int flush);
      for (int i = 0; i < n_pix; i++) begin
         if ($urandom_range(99) < 8)
            add_beat(16'($urandom), 1'b1);
         add_beat(16'($urandom), 1'b0);
      end
      for (int i = 0; i < flush; i++)
         add_beat(16'($urandom), 1'($urandom));
   endtask

   initial begin
      int w, h, n;
      logic [RAW_BITS-1:0] corner [4];
      corner = '{16'h0000, 16'hFFFF, 16'h000F, 16'hFFF0};
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: 8x8 frame of extreme samples, a blank inside the frame,
      // pixels among the flush beats, and a write to a spare address.
      set_frame(0, 8, 8);
      for (int i = 0; i < 64; i++) begin
         if (i == 20) add_beat(16'hFFFF, 1'b1);
         add_beat((i % 5 == 4) ? 16'($urandom) : corner[i % 4], 1'b0);
      end
      for (int i = 0; i < 19; i++)
         add_beat(corner[i % 4], 1'(i & 1));
      settle();
      csr_write(SPARE_ADDR, 32'hFFFF_FFFF);
      // Sizes below the minimum clamp to eight.
      set_frame(3, 3, 0);
      queue_frame(64, 19);
      settle();

      // Random phases: small frames of every pattern, some cut short.
      while (queued < 780) begin
         calm = (queued > 300 && queued < 550);
         w = $urandom_range(8, 20);
         h = $urandom_range(8, 12);
         set_frame($urandom_range(0, 3), w, h);
         if ($urandom_range(99) < 20) begin
            n = $urandom_range(2 * w + 3, w * h - 1);
            queue_frame(n, 0);
         end else begin
            n = w * h;
            queue_frame(n, 2 * w + 3 + $urandom_range(0, 3));
         end
         settle();
      end
      calm = 1'b0;

      // Widest line: a short start of a frame, too short to release a result.
      set_frame(1, MAX_WIDTH, 8);
      queue_frame(40, 0);
      settle();
      // Tallest frame, and oversized sizes that clamp.
      set_frame(2, 8, MAX_HEIGHT);
      queue_frame(120, 0);
      settle();
      set_frame(0, 8191, 8191);
      queue_frame(40, 0);
      settle();

      $display("checked %0d results from %0d input beats over %0d completed frames,",
               checked, queued, frames_done);
      $display("all four patterns, sizes from the clamped minimum to the widest and tallest");
      if (errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

FILE: rgbir_bilinear_remosaic.f
+incdir+rtl/core
rtl/core/rbr_pkg.sv
rtl/core/rbr_line_ram.sv
rtl/core/rbr_ctrl.sv
rtl/core/rbr_interp.sv
rtl/core/rgbir_bilinear_remosaic.sv
sim/rgbir_bilinear_remosaic_tb.sv
